@@ rtl/lpr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LRU page replacement block: defaults, field widths and the
// scan / update records passed between the controller and the frame cells.
// No dependencies.
package lpr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W       = 4;
    localparam int FRAME_OUT_W = 3;
    localparam int COUNT_W     = 32;

    localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(3);

    // Record fields are sized for the largest supported frame count (64).
    localparam int IDX_W  = 6;
    localparam int RANK_W = 6;
    localparam int LIM_W  = 7;

    // Search record, handed cell to cell behind the token.
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              empty;
        logic [IDX_W-1:0]  empty_idx;
        logic [IDX_W-1:0]  best_idx;
        logic [RANK_W-1:0] best_rank;
    } scan_t;

    // Update command, broadcast to all cells at once.
    typedef struct packed {
        logic             valid;
        logic             load;
        logic [IDX_W-1:0] idx;
        logic [LIM_W-1:0] limit;
    } upd_t;

endpackage

@@ rtl/lpr_cell.sv @@
`timescale 1ns / 1ps
// One page frame: page, valid bit and recency rank, plus one stage of the
// lookup chain. Depends on lpr_pkg.
module lpr_cell #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear_i,
    input  logic                 active_i,
    input  logic [PAGE_BITS-1:0] pg_i,
    input  logic                 tok_i,
    input  lpr_pkg::scan_t       scan_i,
    output logic                 tok_o,
    output lpr_pkg::scan_t       scan_o,
    input  lpr_pkg::upd_t        upd_i
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);
    localparam logic [lpr_pkg::IDX_W-1:0] MY_IDX = lpr_pkg::IDX_W'(INDEX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [RW-1:0]        rank_reg;
    logic                 tok_reg;
    lpr_pkg::scan_t       scan_reg;
    lpr_pkg::scan_t       scan_next;
    logic [lpr_pkg::RANK_W-1:0] rank_ext;

    assign rank_ext = lpr_pkg::RANK_W'(rank_reg);

    always_comb begin
        scan_next = scan_i;
        if (active_i) begin
            if (valid_reg && page_reg == pg_i && !scan_i.hit) begin
                scan_next.hit      = 1'b1;
                scan_next.hit_idx  = MY_IDX;
                scan_next.hit_rank = rank_ext;
            end
            if (!valid_reg && !scan_i.empty) begin
                scan_next.empty     = 1'b1;
                scan_next.empty_idx = MY_IDX;
            end
            // strict compare keeps the lowest index on equal ranks
            if (rank_ext > scan_i.best_rank) begin
                scan_next.best_idx  = MY_IDX;
                scan_next.best_rank = rank_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            tok_reg   <= 1'b0;
        end else begin
            tok_reg <= tok_i;
            if (clear_i) begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end else if (upd_i.valid) begin
                if (upd_i.idx == MY_IDX) begin
                    rank_reg <= '0;
                    if (upd_i.load) begin
                        valid_reg <= 1'b1;
                    end
                end else if (active_i && valid_reg
                             && lpr_pkg::LIM_W'(rank_reg) < upd_i.limit
                             && rank_reg != RANK_MAX) begin
                    rank_reg <= rank_reg + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_i) begin
            scan_reg <= scan_next;
        end
        if (upd_i.valid && upd_i.load && upd_i.idx == MY_IDX) begin
            page_reg <= pg_i;
        end
    end

    assign tok_o  = tok_reg;
    assign scan_o = scan_reg;

endmodule

@@ rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// LRU page replacement, top level: controller, fault total and a row of
// frame cells. Depends on lpr_pkg and lpr_cell.
//
// Usage:
//   s_page / s_first arrive on a valid/ready channel. Each item is one page
//   reference; s_first empties all frames and clears the fault total before
//   that reference is looked up.
//   Each item yields one result on m_fault / m_frame_used / m_fault_count
//   (valid/ready). Fault count saturates at all ones.
//   cfg_num_frames sets the frame count (0 acts as 1, above FRAMES acts as
//   FRAMES); write it only while the block is idle.
// Timing:
//   A search token walks the frame cells, one cell per cycle, carrying the
//   hit / first empty / oldest frame found so far. After the last cell the
//   controller broadcasts one update to all cells. s_ready is high only in
//   idle, so a new item is taken only once the previous one has made its
//   update, after its token has walked the whole cell row.
// Reset: all frames empty, ranks zero, total zero, frame count 3.
// Stall: the result sits in an output register; the next item is accepted
//   and searched meanwhile, and waits at its update step until the output
//   register is free.
module lru_page_replacement #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]           cfg_num_frames,
    // reference items in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [PAGE_BITS-1:0]                s_page,
    input  logic                                s_first,
    // result items out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_fault,
    output logic [lpr_pkg::FRAME_OUT_W-1:0]     m_frame_used,
    output logic [lpr_pkg::COUNT_W-1:0]         m_fault_count
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [lpr_pkg::LIM_W-1:0] LIM_ALL = lpr_pkg::LIM_W'(FRAMES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                        state_reg;
    logic [lpr_pkg::CFG_W-1:0]     num_frames_reg;
    logic [PAGE_BITS-1:0]          page_reg;
    logic                          start_reg;
    logic [lpr_pkg::COUNT_W-1:0]   total_reg;
    logic [lpr_pkg::COUNT_W-1:0]   total_next;
    logic                          m_valid_reg;
    logic                          m_fault_reg;
    logic [lpr_pkg::FRAME_OUT_W-1:0] m_frame_reg;
    logic [lpr_pkg::COUNT_W-1:0]   m_count_reg;

    logic                          s_accept;
    logic                          clear;
    logic                          out_free;
    logic [CNT_W-1:0]              n_eff;
    logic [FRAMES-1:0]             active;
    logic [FRAMES:0]               tok;
    lpr_pkg::scan_t                scan [FRAMES+1];
    lpr_pkg::scan_t                res;
    lpr_pkg::upd_t                 upd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign clear     = s_accept && s_first;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // effective frame count, clamped to 1..FRAMES
    always_comb begin
        if (num_frames_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(num_frames_reg) > 32'(FRAMES)) begin
            n_eff = CNT_W'(FRAMES);
        end else begin
            n_eff = CNT_W'(num_frames_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            active[i] = (32'(n_eff) > 32'(i));
        end
    end

    // search chain: token enters cell 0 the cycle after accept
    assign tok[0]  = start_reg;
    assign scan[0] = '0;
    assign res     = scan[FRAMES];

    generate
        for (genvar g = 0; g < FRAMES; g++) begin : g_cell
            lpr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .INDEX     (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .clear_i  (clear),
                .active_i (active[g]),
                .pg_i     (page_reg),
                .tok_i    (tok[g]),
                .scan_i   (scan[g]),
                .tok_o    (tok[g+1]),
                .scan_o   (scan[g+1]),
                .upd_i    (upd)
            );
        end
    endgenerate

    // decision from the end of the chain: hit, fill, or evict the oldest
    always_comb begin
        upd.valid = (state_reg == ST_UPDATE) && out_free;
        if (res.hit) begin
            upd.load  = 1'b0;
            upd.idx   = res.hit_idx;
            upd.limit = lpr_pkg::LIM_W'(res.hit_rank);
        end else if (res.empty) begin
            upd.load  = 1'b1;
            upd.idx   = res.empty_idx;
            upd.limit = LIM_ALL;
        end else begin
            upd.load  = 1'b1;
            upd.idx   = res.best_idx;
            upd.limit = lpr_pkg::LIM_W'(res.best_rank);
        end
    end

    always_comb begin
        total_next = total_reg;
        if (!res.hit && !(&total_reg)) begin
            total_next = total_reg + lpr_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_frames_reg <= lpr_pkg::NUM_FRAMES_RST;
            start_reg      <= 1'b0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            start_reg <= s_accept;
            if (cfg_valid && cfg_ready) begin
                num_frames_reg <= cfg_num_frames;
            end
            // a result leaving in the update cycle is replaced below
            if (m_valid_reg && m_ready && !upd.valid) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_SCAN;
                        if (s_first) begin
                            total_reg <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (tok[FRAMES]) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        total_reg   <= total_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg <= s_page;
        end
        if (upd.valid) begin
            m_fault_reg <= !res.hit;
            m_frame_reg <= lpr_pkg::FRAME_OUT_W'(upd.idx);
            m_count_reg <= total_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fault       = m_fault_reg;
    assign m_frame_used  = m_frame_reg;
    assign m_fault_count = m_count_reg;

endmodule
